/* src/alu8080_pkg.sv */
// Shared types and constants for the 8080-style ALU pipeline.
// Used by every stage module and by the top level; depends on nothing.
package alu8080_pkg;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0,
        OP_ADC = 5'd1,
        OP_SUB = 5'd2,
        OP_SBB = 5'd3,
        OP_ANA = 5'd4,
        OP_XRA = 5'd5,
        OP_ORA = 5'd6,
        OP_CMP = 5'd7,
        OP_INR = 5'd8,
        OP_DCR = 5'd9,
        OP_RLC = 5'd10,
        OP_RRC = 5'd11,
        OP_RAL = 5'd12,
        OP_RAR = 5'd13,
        OP_DAA = 5'd14,
        OP_CMA = 5'd15,
        OP_STC = 5'd16,
        OP_CMC = 5'd17
    } t_opcode;

    localparam logic [7:0] BCD_MAX    = 8'h99;
    localparam logic [3:0] DIGIT_MAX  = 4'h9;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [3:0] NIBBLE_ALL = 4'hF;

    typedef struct packed {
        logic sign;
        logic zero;
        logic aux;
        logic parity;
        logic carry;
    } t_flags;

    // Decoded item handed from the decode stage to the execute stage.
    typedef struct packed {
        t_opcode    op;
        logic [7:0] accum;
        logic [7:0] operand;
        t_flags     flags;
        logic       cin;      // carry or borrow fed into the adder
        logic       daa_hi;   // decimal adjust adds 0x60
        logic       daa_lo;   // decimal adjust adds 0x06
        logic       daa_gt9;  // low digit of the accumulator is above 9
    } t_dec;

    // Executed item handed from the execute stage to the flag stage.
    typedef struct packed {
        logic [7:0] result;
        logic [7:0] fval;     // value that sign, zero and parity are taken from
        logic       zsp;      // sign, zero and parity are updated
        t_flags     flags;
    } t_exe;

    // Packed output word: result, then sign, zero, aux, parity, carry.
    typedef struct packed {
        logic [7:0] result;
        t_flags     flags;
    } t_res;

endpackage

/* src/alu8080_decode.sv */
// Decode stage: unpacks the input transaction, decodes the operation and
// precomputes the adder carry-in and the decimal adjust conditions. Uses alu8080_pkg.
module alu8080_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [4:0]          i_opcode,
    input  logic [7:0]          i_accum,
    input  logic [7:0]          i_operand,
    input  alu8080_pkg::t_flags i_flags,
    output logic                o_valid,
    input  logic                i_ready,
    output alu8080_pkg::t_dec   o_dec
);

    logic              r_valid;
    alu8080_pkg::t_dec r_dec;
    alu8080_pkg::t_dec n_dec;

    always_comb begin
        n_dec         = '0;
        n_dec.op      = alu8080_pkg::t_opcode'(i_opcode);
        n_dec.accum   = i_accum;
        n_dec.operand = i_operand;
        n_dec.flags   = i_flags;
        n_dec.cin     = ((n_dec.op == alu8080_pkg::OP_ADC) ||
                         (n_dec.op == alu8080_pkg::OP_SBB)) ? i_flags.carry : 1'b0;
        n_dec.daa_gt9 = (i_accum[3:0] > alu8080_pkg::DIGIT_MAX);
        n_dec.daa_hi  = i_flags.carry || (i_accum > alu8080_pkg::BCD_MAX);
        n_dec.daa_lo  = i_flags.aux || n_dec.daa_gt9;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

/* src/alu8080_exec.sv */
// Execute stage: adder, logic unit, rotates and decimal adjust. Produces the
// result, the carry and aux flags, and the value for the later flag stage. Uses alu8080_pkg.
module alu8080_exec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  alu8080_pkg::t_dec i_dec,
    output logic              o_valid,
    input  logic              i_ready,
    output alu8080_pkg::t_exe o_exe
);

    logic              r_valid;
    alu8080_pkg::t_exe r_exe;
    alu8080_pkg::t_exe n_exe;
    logic [8:0]        w_sum;
    logic [8:0]        w_diff;
    logic [7:0]        w_a;
    logic [7:0]        w_v;

    assign w_a    = i_dec.accum;
    assign w_v    = i_dec.operand;
    assign w_sum  = {1'b0, w_a} + {1'b0, w_v} + {8'b0, i_dec.cin};
    assign w_diff = {1'b0, w_a} - {1'b0, w_v} - {8'b0, i_dec.cin};

    always_comb begin
        n_exe        = '0;
        n_exe.result = w_a;
        n_exe.fval   = w_a;
        n_exe.zsp    = 1'b0;
        n_exe.flags  = i_dec.flags;
        case (i_dec.op)
            alu8080_pkg::OP_ADD, alu8080_pkg::OP_ADC: begin
                n_exe.result      = w_sum[7:0];
                n_exe.fval        = w_sum[7:0];
                n_exe.flags.aux   = w_sum[4] ^ w_a[4] ^ w_v[4];
                n_exe.flags.carry = w_sum[8];
                n_exe.zsp         = 1'b1;
            end
            alu8080_pkg::OP_SUB, alu8080_pkg::OP_SBB, alu8080_pkg::OP_CMP: begin
                // Compare keeps the accumulator and only updates the flags.
                n_exe.result      = (i_dec.op == alu8080_pkg::OP_CMP) ? w_a : w_diff[7:0];
                n_exe.fval        = w_diff[7:0];
                n_exe.flags.aux   = ~(w_diff[4] ^ w_a[4] ^ w_v[4]);
                n_exe.flags.carry = w_diff[8];
                n_exe.zsp         = 1'b1;
            end
            alu8080_pkg::OP_ANA: begin
                n_exe.result      = w_a & w_v;
                n_exe.fval        = w_a & w_v;
                n_exe.flags.aux   = w_a[3] | w_v[3];
                n_exe.flags.carry = 1'b0;
                n_exe.zsp         = 1'b1;
            end
            alu8080_pkg::OP_XRA: begin
                n_exe.result      = w_a ^ w_v;
                n_exe.fval        = w_a ^ w_v;
                n_exe.flags.aux   = 1'b0;
                n_exe.flags.carry = 1'b0;
                n_exe.zsp         = 1'b1;
            end
            alu8080_pkg::OP_ORA: begin
                n_exe.result      = w_a | w_v;
                n_exe.fval        = w_a | w_v;
                n_exe.flags.aux   = 1'b0;
                n_exe.flags.carry = 1'b0;
                n_exe.zsp         = 1'b1;
            end
            alu8080_pkg::OP_INR: begin
                n_exe.result    = w_v + 8'd1;
                n_exe.fval      = w_v + 8'd1;
                n_exe.flags.aux = (w_v[3:0] == alu8080_pkg::NIBBLE_ALL);
                n_exe.zsp       = 1'b1;
            end
            alu8080_pkg::OP_DCR: begin
                // The new low digit is 0xF only when the old one was zero.
                n_exe.result    = w_v - 8'd1;
                n_exe.fval      = w_v - 8'd1;
                n_exe.flags.aux = (w_v[3:0] != 4'h0);
                n_exe.zsp       = 1'b1;
            end
            alu8080_pkg::OP_RLC: begin
                n_exe.result      = {w_a[6:0], w_a[7]};
                n_exe.flags.carry = w_a[7];
            end
            alu8080_pkg::OP_RRC: begin
                n_exe.result      = {w_a[0], w_a[7:1]};
                n_exe.flags.carry = w_a[0];
            end
            alu8080_pkg::OP_RAL: begin
                n_exe.result      = {w_a[6:0], i_dec.flags.carry};
                n_exe.flags.carry = w_a[7];
            end
            alu8080_pkg::OP_RAR: begin
                n_exe.result      = {i_dec.flags.carry, w_a[7:1]};
                n_exe.flags.carry = w_a[0];
            end
            alu8080_pkg::OP_DAA: begin
                n_exe.result = w_a + (i_dec.daa_hi ? alu8080_pkg::DAA_HI_ADJ : 8'h00)
                                   + (i_dec.daa_lo ? alu8080_pkg::DAA_LO_ADJ : 8'h00);
                n_exe.fval   = n_exe.result;
                if (i_dec.daa_hi) begin
                    n_exe.flags.carry = 1'b1;
                end
                if (i_dec.daa_lo) begin
                    n_exe.flags.aux = i_dec.daa_gt9;
                end
                n_exe.zsp = 1'b1;
            end
            alu8080_pkg::OP_CMA: begin
                n_exe.result = ~w_a;
            end
            alu8080_pkg::OP_STC: begin
                n_exe.flags.carry = 1'b1;
            end
            alu8080_pkg::OP_CMC: begin
                n_exe.flags.carry = ~i_dec.flags.carry;
            end
            default: begin
                // Unassigned codes leave everything unchanged.
                n_exe.result = w_a;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_exe <= n_exe;
        end
    end

    assign o_valid = r_valid;
    assign o_exe   = r_exe;

endmodule

/* src/alu8080_flags.sv */
// Flag stage and output register: derives sign, zero and parity from the
// executed value and holds the finished transaction for the output. Uses alu8080_pkg.
module alu8080_flags (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  alu8080_pkg::t_exe i_exe,
    output logic              o_valid,
    input  logic              i_ready,
    output alu8080_pkg::t_res o_res
);

    logic              r_valid;
    alu8080_pkg::t_res r_res;
    alu8080_pkg::t_res n_res;

    always_comb begin
        n_res.result = i_exe.result;
        n_res.flags  = i_exe.flags;
        if (i_exe.zsp) begin
            n_res.flags.sign   = i_exe.fval[7];
            n_res.flags.zero   = (i_exe.fval == 8'h00);
            n_res.flags.parity = ~(^i_exe.fval);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* src/cpu8080_alu_flags.sv */
// 8080-style 8-bit ALU with flag logic, built as a three-stage pipeline
// (decode, execute, flags). It takes one transaction per clock cycle unless the
// output stalls; each result passes the decode, execute and flag registers.
// Each stage holds one transaction, so up to three are in flight and a stall
// on the output backs up stage by stage without losing or repeating anything.
// Operations without a defined code pass the accumulator and all flags through.
module cpu8080_alu_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[4:0], accum[12:5], operand[20:13], sign_in[21], zero_in[22],
    // aux_in[23], parity_in[24], carry_in[25], zero fill[31:26]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[7:0], sign_out[8], zero_out[9], aux_out[10], parity_out[11],
    // carry_out[12], zero fill[15:13]
    output logic [15:0] m_axis_tdata
);

    alu8080_pkg::t_flags w_in_flags;
    alu8080_pkg::t_dec   w_dec;
    alu8080_pkg::t_exe   w_exe;
    alu8080_pkg::t_res   w_res;
    logic                w_dec_valid;
    logic                w_dec_ready;
    logic                w_exe_valid;
    logic                w_exe_ready;

    assign w_in_flags.sign   = s_axis_tdata[21];
    assign w_in_flags.zero   = s_axis_tdata[22];
    assign w_in_flags.aux    = s_axis_tdata[23];
    assign w_in_flags.parity = s_axis_tdata[24];
    assign w_in_flags.carry  = s_axis_tdata[25];

    alu8080_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_opcode  (s_axis_tdata[4:0]),
        .i_accum   (s_axis_tdata[12:5]),
        .i_operand (s_axis_tdata[20:13]),
        .i_flags   (w_in_flags),
        .o_valid   (w_dec_valid),
        .i_ready   (w_dec_ready),
        .o_dec     (w_dec)
    );

    alu8080_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dec_valid),
        .o_ready (w_dec_ready),
        .i_dec   (w_dec),
        .o_valid (w_exe_valid),
        .i_ready (w_exe_ready),
        .o_exe   (w_exe)
    );

    alu8080_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_exe_valid),
        .o_ready (w_exe_ready),
        .i_exe   (w_exe),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    assign m_axis_tdata = {3'b000, w_res.flags.carry, w_res.flags.parity, w_res.flags.aux,
                           w_res.flags.zero, w_res.flags.sign, w_res.result};

    // The input side only stalls when every stage holds a transaction.
    a_full_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (w_dec_valid && w_exe_valid && m_axis_tvalid))
        else $error("input stalled while a pipeline stage was empty");

    // An accepted transaction always lands in the decode stage.
    a_accept_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> w_dec_valid)
        else $error("accepted transaction did not reach the decode stage");

    // A stalled execute stage keeps its transaction.
    a_exec_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exe_valid && !w_exe_ready) |=> (w_exe_valid && $stable(w_exe)))
        else $error("execute stage dropped or changed a stalled transaction");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the cpu8080_alu_flags stream ALU.
// Predicts every result from the accepted input transaction and compares it
// field by field; depends only on alu8080_pkg and the top-level RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [4:0] OP_UNDEF_FIRST = alu8080_pkg::OP_CMC + 5'd1;
    localparam logic [4:0] OP_UNDEF_LAST  = 5'h1F;
    localparam alu8080_pkg::t_flags FLAGS_CLEAR = '0;
    localparam alu8080_pkg::t_flags FLAGS_SET   = '1;

    typedef struct packed {
        logic [7:0]          value;
        alu8080_pkg::t_flags flags;
    } t_alu_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // opcode[4:0], accum[12:5], operand[20:13], sign_in[21], zero_in[22],
    // aux_in[23], parity_in[24], carry_in[25], zero fill[31:26]
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // result[7:0], sign_out[8], zero_out[9], aux_out[10], parity_out[11],
    // carry_out[12], zero fill[15:13]
    logic [15:0] m_axis_tdata;

    t_alu_out expected_q[$];
    int       fail_count = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    bit       hold_request = 1'b0;
    int       stall_mode = 0;
    int       stall_left = 0;
    int       rx_phase = 0;

    cpu8080_alu_flags DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_alu_out alu_predict(input logic [4:0] op, input logic [7:0] a,
                                             input logic [7:0] v,
                                             input alu8080_pkg::t_flags f);
        t_alu_out   o;
        logic [8:0] wide;
        logic [7:0] fv;
        logic       zsp;
        logic       cin;
        o.value = a;
        o.flags = f;
        fv = '0;
        zsp = 1'b0;
        case (op)
            alu8080_pkg::OP_ADD, alu8080_pkg::OP_ADC: begin
                cin = (op == alu8080_pkg::OP_ADC) ? f.carry : 1'b0;
                wide = {1'b0, a} + {1'b0, v} + {8'b0, cin};
                o.value = wide[7:0];
                o.flags.aux = wide[4] ^ a[4] ^ v[4];
                o.flags.carry = wide[8];
                fv = wide[7:0];
                zsp = 1'b1;
            end
            alu8080_pkg::OP_SUB, alu8080_pkg::OP_SBB, alu8080_pkg::OP_CMP: begin
                cin = (op == alu8080_pkg::OP_SBB) ? f.carry : 1'b0;
                wide = {1'b0, a} - {1'b0, v} - {8'b0, cin};
                // Aux after a subtraction is the inverted borrow into bit 4.
                o.flags.aux = ~(wide[4] ^ a[4] ^ v[4]);
                o.flags.carry = wide[8];
                fv = wide[7:0];
                zsp = 1'b1;
                if (op != alu8080_pkg::OP_CMP) begin
                    o.value = wide[7:0];
                end
            end
            alu8080_pkg::OP_ANA: begin
                o.value = a & v;
                o.flags.aux = a[3] | v[3];
                o.flags.carry = 1'b0;
                fv = o.value;
                zsp = 1'b1;
            end
            alu8080_pkg::OP_XRA, alu8080_pkg::OP_ORA: begin
                o.value = (op == alu8080_pkg::OP_XRA) ? (a ^ v) : (a | v);
                o.flags.aux = 1'b0;
                o.flags.carry = 1'b0;
                fv = o.value;
                zsp = 1'b1;
            end
            alu8080_pkg::OP_INR: begin
                o.value = v + 8'd1;
                o.flags.aux = (o.value[3:0] == 4'h0);
                fv = o.value;
                zsp = 1'b1;
            end
            alu8080_pkg::OP_DCR: begin
                o.value = v - 8'd1;
                o.flags.aux = (o.value[3:0] != alu8080_pkg::NIBBLE_ALL);
                fv = o.value;
                zsp = 1'b1;
            end
            alu8080_pkg::OP_RLC: begin
                o.value = {a[6:0], a[7]};
                o.flags.carry = a[7];
            end
            alu8080_pkg::OP_RRC: begin
                o.value = {a[0], a[7:1]};
                o.flags.carry = a[0];
            end
            alu8080_pkg::OP_RAL: begin
                o.value = {a[6:0], f.carry};
                o.flags.carry = a[7];
            end
            alu8080_pkg::OP_RAR: begin
                o.value = {f.carry, a[7:1]};
                o.flags.carry = a[0];
            end
            alu8080_pkg::OP_DAA: begin
                if (f.carry || a > alu8080_pkg::BCD_MAX) begin
                    o.flags.carry = 1'b1;
                    o.value = a + alu8080_pkg::DAA_HI_ADJ;
                end
                if (f.aux || o.value[3:0] > alu8080_pkg::DIGIT_MAX) begin
                    o.flags.aux = (o.value[3:0] > alu8080_pkg::DIGIT_MAX);
                    o.value = o.value + alu8080_pkg::DAA_LO_ADJ;
                end
                fv = o.value;
                zsp = 1'b1;
            end
            alu8080_pkg::OP_CMA: o.value = ~a;
            alu8080_pkg::OP_STC: o.flags.carry = 1'b1;
            alu8080_pkg::OP_CMC: o.flags.carry = ~f.carry;
            default: ;
        endcase
        if (zsp) begin
            o.flags.sign = fv[7];
            o.flags.zero = (fv == 8'h00);
            o.flags.parity = ~^fv;
        end
        return o;
    endfunction

    function automatic t_alu_out predict_word(input logic [31:0] w);
        alu8080_pkg::t_flags f;
        f.sign   = w[21];
        f.zero   = w[22];
        f.aux    = w[23];
        f.parity = w[24];
        f.carry  = w[25];
        return alu_predict(w[4:0], w[12:5], w[20:13], f);
    endfunction

    task automatic compare_result(input logic [15:0] d);
        t_alu_out got;
        t_alu_out want;
        got.value        = d[7:0];
        got.flags.sign   = d[8];
        got.flags.zero   = d[9];
        got.flags.aux    = d[10];
        got.flags.parity = d[11];
        got.flags.carry  = d[12];
        if (expected_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: result %h arrived with nothing expected", $realtime, got.value);
        end else begin
            want = expected_q.pop_front();
            if (got.value !== want.value || got.flags.sign !== want.flags.sign ||
                got.flags.zero !== want.flags.zero || got.flags.aux !== want.flags.aux ||
                got.flags.parity !== want.flags.parity ||
                got.flags.carry !== want.flags.carry) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: mismatch result exp %h got %h, szapc exp %b got %b",
                             $realtime, want.value, got.value, want.flags, got.flags);
            end
        end
    endtask

    // Outputs are checked before the same edge's input is queued, so the
    // order of processes within a time step cannot matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                compare_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(predict_word(s_axis_tdata));
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall modes, each held for a random stretch, plus
    // one long hold-off when a test asks for it.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                if (stall_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    stall_left = $urandom_range(16, 96);
                end
                stall_left--;
                rx_phase++;
                case (stall_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (rx_phase % 5 != 0);
                endcase
            end
        end
    end

    // Sends one transaction; unless steady is set, bursts of random length
    // are separated by random gaps, and some bursts follow with no gap.
    task automatic send_op(input logic [4:0] op, input logic [7:0] a, input logic [7:0] v,
                           input alu8080_pkg::t_flags f, input bit steady);
        int gap;
        if (!steady && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, f.carry, f.parity, f.aux, f.zero, f.sign, v, a, op};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0)
            burst_left--;
    endtask

    function automatic logic [4:0] random_opcode();
        if ($urandom_range(0, 9) == 0)
            return 5'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
        return 5'($urandom_range(alu8080_pkg::OP_ADD, alu8080_pkg::OP_CMC));
    endfunction

    function automatic alu8080_pkg::t_flags random_flags();
        return alu8080_pkg::t_flags'(5'($urandom_range(0, 31)));
    endfunction

    task automatic test_directed_cases();
        send_op(alu8080_pkg::OP_ADD, 8'hFF, 8'h01, FLAGS_CLEAR, 1'b0);
        send_op(alu8080_pkg::OP_ADC, 8'hFF, 8'h00, FLAGS_SET, 1'b0);
        send_op(alu8080_pkg::OP_SUB, 8'h00, 8'h01, FLAGS_CLEAR, 1'b0);
        send_op(alu8080_pkg::OP_SUB, 8'h55, 8'h55, FLAGS_SET, 1'b0);
        send_op(alu8080_pkg::OP_SBB, 8'h00, 8'hFF, FLAGS_SET, 1'b0);
        send_op(alu8080_pkg::OP_CMP, 8'h10, 8'h20, FLAGS_CLEAR, 1'b0);
        send_op(alu8080_pkg::OP_CMP, 8'h42, 8'h42, FLAGS_CLEAR, 1'b0);
        send_op(alu8080_pkg::OP_ANA, 8'hF0, 8'h08, FLAGS_SET, 1'b0);
        send_op(alu8080_pkg::OP_XRA, 8'hFF, 8'hFF, FLAGS_SET, 1'b0);
        send_op(alu8080_pkg::OP_ORA, 8'h00, 8'h00, FLAGS_SET, 1'b0);
        send_op(alu8080_pkg::OP_INR, 8'h00, 8'hFF, FLAGS_SET, 1'b0);
        send_op(alu8080_pkg::OP_INR, 8'h00, 8'h0F, FLAGS_CLEAR, 1'b0);
        send_op(alu8080_pkg::OP_DCR, 8'h00, 8'h00, FLAGS_CLEAR, 1'b0);
        send_op(alu8080_pkg::OP_DCR, 8'h00, 8'h10, FLAGS_SET, 1'b0);
        send_op(alu8080_pkg::OP_RLC, 8'h80, 8'h00, FLAGS_CLEAR, 1'b0);
        send_op(alu8080_pkg::OP_RRC, 8'h01, 8'h00, FLAGS_CLEAR, 1'b0);
        send_op(alu8080_pkg::OP_RAL, 8'h7F, 8'h00, FLAGS_SET, 1'b0);
        send_op(alu8080_pkg::OP_RAR, 8'hFE, 8'h00, FLAGS_SET, 1'b0);
        // Decimal adjust: low digit out of range and value above 0x99, then both
        // adjustments forced by the incoming carry and aux with digits in range.
        send_op(alu8080_pkg::OP_DAA, 8'h9A, 8'h00, FLAGS_CLEAR, 1'b0);
        send_op(alu8080_pkg::OP_DAA, 8'h00, 8'h00, FLAGS_SET, 1'b0);
        send_op(alu8080_pkg::OP_CMA, 8'hA5, 8'hFF, FLAGS_CLEAR, 1'b0);
        send_op(alu8080_pkg::OP_STC, 8'h3C, 8'h00, FLAGS_CLEAR, 1'b0);
        send_op(alu8080_pkg::OP_CMC, 8'hC3, 8'h00, FLAGS_SET, 1'b0);
        send_op(OP_UNDEF_FIRST, 8'h5A, 8'hA5, FLAGS_SET, 1'b0);
        send_op(OP_UNDEF_LAST, 8'hFF, 8'hFF, FLAGS_CLEAR, 1'b0);
    endtask

    task automatic test_random_ops(input int count);
        repeat (count)
            send_op(random_opcode(), 8'($urandom), 8'($urandom), random_flags(), 1'b0);
    endtask

    // Packed BCD addition followed by a decimal adjust that sees the flags of
    // the addition, the way a program would use it; a few operands are not BCD.
    task automatic test_bcd_add_adjust(input int count);
        logic [7:0]          x;
        logic [7:0]          y;
        logic [4:0]          op;
        alu8080_pkg::t_flags f;
        t_alu_out            sum;
        repeat (count) begin
            x = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            y = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            if ($urandom_range(0, 9) == 0)
                x = 8'($urandom);
            op = ($urandom_range(0, 1) == 1) ? alu8080_pkg::OP_ADC : alu8080_pkg::OP_ADD;
            f = random_flags();
            sum = alu_predict(op, x, y, f);
            send_op(op, x, y, f, 1'b0);
            send_op(alu8080_pkg::OP_DAA, sum.value, 8'($urandom), sum.flags, 1'b0);
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the pipeline fills and must stall its input.
    task automatic test_output_backpressure(input int count);
        hold_request = 1'b1;
        repeat (count)
            send_op(random_opcode(), 8'($urandom), 8'($urandom), random_flags(), 1'b1);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_ops(1000);
        test_bcd_add_adjust(120);
        test_output_backpressure(150);
        test_random_ops(300);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
